[design/psc_pkg.sv]
// Package for the position sensor conditioner.
// Holds the item kinds, register indexes, sequencer states, widths and register resets.
// Used by psc_divider and position_sensor_conditioner_core.
`timescale 1ns / 1ps

package psc_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int FILT_BITS    = SAMPLE_BITS + 8;       // filter state, counts x256
    localparam int MUL_B_BITS   = 9;                     // 256 - alpha needs 9 bits
    localparam int MUL_P_BITS   = FILT_BITS + MUL_B_BITS;
    localparam int DIVIDEND_BITS = 24;                   // |diff| * num < 2^24
    localparam int DIVISOR_BITS = 8;
    localparam int DIV_CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    localparam int CFG_DATA_BITS = 12;
    localparam int OUT_DATA_BITS = 72;                   // 66 payload bits, byte padded
    localparam int IN_DATA_BITS  = 32;                   // 28 payload bits, byte padded

    // register reset values
    localparam logic [7:0]  ALPHA_RST     = 8'd240;
    localparam logic [7:0]  NUM_RST       = 8'd37;
    localparam logic [7:0]  DEN_RST       = 8'd10;
    localparam logic [11:0] MIN_RST       = 12'd10;
    localparam logic [11:0] MAX_RST       = 12'd4090;
    localparam logic [7:0]  STUCK_LIM_RST = 8'd10;
    localparam logic [7:0]  TMO_LIM_RST   = 8'd3;
    localparam logic [7:0]  MOTION_RST    = 8'd2;

    localparam logic [7:0]  COUNT_MAX     = 8'd255;
    localparam logic [MUL_B_BITS-1:0] ALPHA_ONE = MUL_B_BITS'(256);

    typedef enum logic [2:0] {
        KIND_SAMPLE      = 3'd0,
        KIND_TIMEOUT     = 3'd1,
        KIND_INIT        = 3'd2,
        KIND_ZERO_CAL    = 3'd3,
        KIND_ZERO_ONLY   = 3'd4,
        KIND_LOAD_OFFSET = 3'd5,
        KIND_CLEAR_FAULT = 3'd6
    } psc_kind_t;

    typedef enum logic [2:0] {
        CFG_ALPHA      = 3'd0,
        CFG_NUM        = 3'd1,
        CFG_DEN        = 3'd2,
        CFG_MIN        = 3'd3,
        CFG_MAX        = 3'd4,
        CFG_STUCK_LIM  = 3'd5,
        CFG_TMO_LIM    = 3'd6,
        CFG_MOTION     = 3'd7
    } psc_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_SCALE,
        ST_DIV,
        ST_REPORT
    } psc_state_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } psc_div_stat_t;

endpackage

[design/psc_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on psc_pkg for widths and the status struct.
`timescale 1ns / 1ps

module psc_divider
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [psc_pkg::DIVIDEND_BITS-1:0]    dividend,
    input  logic [psc_pkg::DIVISOR_BITS-1:0]     divisor,
    output psc_pkg::psc_div_stat_t               stat
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [psc_pkg::DIV_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [psc_pkg::DIVISOR_BITS-1:0]    rem_reg, rem_next;
    logic [psc_pkg::DIVISOR_BITS-1:0]    den_reg, den_next;
    logic [psc_pkg::DIVIDEND_BITS-1:0]   quo_reg, quo_next;
    logic [psc_pkg::DIVISOR_BITS:0]      trial;
    logic [psc_pkg::DIVISOR_BITS:0]      trial_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        // shift in the next dividend bit, subtract when it fits
        trial     = {rem_reg, quo_reg[psc_pkg::DIVIDEND_BITS-1]};
        trial_sub = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = psc_pkg::DIV_CNT_BITS'(psc_pkg::DIVIDEND_BITS);
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial_sub[psc_pkg::DIVISOR_BITS-1:0];
                quo_next = {quo_reg[psc_pkg::DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[psc_pkg::DIVISOR_BITS-1:0];
                quo_next = {quo_reg[psc_pkg::DIVIDEND_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - psc_pkg::DIV_CNT_BITS'(1);
            if (cnt_reg == psc_pkg::DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

[design/position_sensor_conditioner_core.sv]
// Top level of the position sensor conditioner: sequencer, shared multiplier, state.
// Depends on psc_pkg and psc_divider.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream (s_axis_*): one transaction per item. tuser carries the item
//   kind (sample, timeout, init, zero+calibrate, zero only, load offset, clear
//   fault); tdata carries the raw sample and the offset value.
//   Output stream (m_axis_*): exactly one result transaction per input item,
//   reporting depth, delta, direction, last raw sample, zero offset and flags.
//   Config port: cfg_we/cfg_index/cfg_data writes one register per cycle; write
//   only while the block is idle.
//
// Processing:
//   A valid sample is accepted in idle, then takes two multiply passes (old and new
//   filter terms), one scale multiply, the bit-serial division, a wait state that
//   collects the quotient and the report state. The bit-serial divider dominates
//   the latency. All other items go from accept straight to the report state.
//   One item is in flight at a time.
//
// Reset: registers return to their defaults, all conditioning state clears,
//   the block is not ready until an init item arrives.
// Stall: a result sits in the output register until m_axis_tready; no new
//   item is accepted while it waits.

module position_sensor_conditioner_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config write port
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [psc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [psc_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // [11:0] sample, [27:12] offset_value
    input  logic [2:0]                            s_axis_tuser,  // [2:0] kind
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [15:0] depth, [32:16] depth_delta, [34:33] direction, [46:35] raw_sample,
    // [62:47] zero_offset, [63] fault, [64] calibrated, [65] ready_res
    output logic [psc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

    localparam int SB = psc_pkg::SAMPLE_BITS;
    localparam int FB = psc_pkg::FILT_BITS;
    localparam int PB = psc_pkg::MUL_P_BITS;

    // configuration registers
    logic [7:0]     alpha_reg, num_reg, den_reg, stuck_lim_reg, tmo_lim_reg, motion_reg;
    logic [11:0]    min_reg, max_reg;

    // conditioning state
    psc_pkg::psc_state_t      state_reg, state_next;
    logic [FB-1:0]            filt_reg, filt_next;
    logic signed [15:0]       depth_now_reg, depth_now_next;
    logic signed [15:0]       depth_before_reg, depth_before_next;
    logic signed [15:0]       zero_ref_reg, zero_ref_next;
    logic [SB-1:0]            raw_last_reg, raw_last_next;
    logic [SB-1:0]            prev_raw_reg, prev_raw_next;
    logic [7:0]               stuck_cnt_reg, stuck_cnt_next;
    logic [7:0]               tmo_cnt_reg, tmo_cnt_next;
    logic                     fault_reg, fault_next;
    logic                     cal_reg, cal_next;
    logic                     ready_reg, ready_next;

    // working registers
    logic [SB-1:0]            samp_reg, samp_next;
    logic [PB-1:0]            acc_reg, acc_next;
    logic                     neg_reg, neg_next;

    // output register
    logic                                 out_valid_reg, out_valid_next;
    logic [psc_pkg::OUT_DATA_BITS-1:0]    out_data_reg, out_data_next;

    // item fields
    psc_pkg::psc_kind_t       in_kind;
    logic [SB-1:0]            in_sample;
    logic signed [15:0]       in_offset;
    logic                     accept;

    // shared multiplier
    logic [FB-1:0]                     mul_a;
    logic [psc_pkg::MUL_B_BITS-1:0]    mul_b;
    logic [PB-1:0]                     mul_p;
    logic [PB:0]                       filt_sum;

    // misc datapath
    logic signed [15:0]       filt_counts;
    logic signed [16:0]       diff;
    logic [15:0]              diff_mag;
    logic [7:0]               stuck_inc, tmo_inc;
    logic signed [16:0]       delta;
    logic signed [16:0]       thr;
    logic [1:0]               dir;
    logic [psc_pkg::DIVISOR_BITS-1:0] div_den;
    logic                     div_start;
    psc_pkg::psc_div_stat_t   div_stat;
    logic signed [15:0]       depth_sat;

    assign in_kind   = psc_pkg::psc_kind_t'(s_axis_tuser);
    assign in_sample = s_axis_tdata[SB-1:0];
    assign in_offset = s_axis_tdata[SB+15:SB];

    assign s_axis_tready = (state_reg == psc_pkg::ST_IDLE) && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign mul_p    = mul_a * mul_b;
    assign filt_sum = {1'b0, acc_reg} + {1'b0, mul_p[PB-9:0], 8'b0};

    // filtered/256 as a 16-bit two's complement count
    assign filt_counts = 16'(filt_reg[FB-1:8]);
    assign diff        = 17'(filt_counts) - 17'(zero_ref_reg);
    assign diff_mag    = diff[16] ? 16'(-diff) : diff[15:0];

    assign stuck_inc = (stuck_cnt_reg == psc_pkg::COUNT_MAX) ? stuck_cnt_reg : stuck_cnt_reg + 8'd1;
    assign tmo_inc   = (tmo_cnt_reg == psc_pkg::COUNT_MAX) ? tmo_cnt_reg : tmo_cnt_reg + 8'd1;

    assign div_den = (den_reg == '0) ? 8'd1 : den_reg;

    // saturate the signed quotient to 16 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (div_stat.quotient > 24'd32768)
                depth_sat = 16'sh8000;
            else
                depth_sat = 16'(-div_stat.quotient[15:0]);
        end
        else
        begin
            if (div_stat.quotient > 24'd32767)
                depth_sat = 16'sh7FFF;
            else
                depth_sat = div_stat.quotient[15:0];
        end
    end

    // result from the registered state
    assign delta = 17'(depth_now_reg) - 17'(depth_before_reg);
    assign thr   = {9'b0, motion_reg};
    always_comb
    begin
        if (delta > thr)
            dir = 2'b11;
        else if (delta < -thr)
            dir = 2'b01;
        else
            dir = 2'b00;
    end

    psc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p[psc_pkg::DIVIDEND_BITS-1:0]),
        .divisor  (div_den),
        .stat     (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        filt_next         = filt_reg;
        depth_now_next    = depth_now_reg;
        depth_before_next = depth_before_reg;
        zero_ref_next     = zero_ref_reg;
        raw_last_next     = raw_last_reg;
        prev_raw_next     = prev_raw_reg;
        stuck_cnt_next    = stuck_cnt_reg;
        tmo_cnt_next      = tmo_cnt_reg;
        fault_next        = fault_reg;
        cal_next          = cal_reg;
        ready_next        = ready_reg;
        samp_next         = samp_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = psc_pkg::ST_REPORT;
                    case (in_kind)
                        psc_pkg::KIND_SAMPLE:
                        begin
                            if (ready_reg)
                            begin
                                if (in_sample < min_reg || in_sample > max_reg)
                                    fault_next = 1'b1;
                                else
                                begin
                                    if (in_sample == prev_raw_reg)
                                    begin
                                        stuck_cnt_next = stuck_inc;
                                        if (stuck_inc >= stuck_lim_reg)
                                            fault_next = 1'b1;
                                    end
                                    else
                                        stuck_cnt_next = '0;
                                    prev_raw_next = in_sample;
                                    tmo_cnt_next  = '0;
                                    raw_last_next = in_sample;
                                    samp_next     = in_sample;
                                    state_next    = psc_pkg::ST_MUL_OLD;
                                end
                            end
                        end
                        psc_pkg::KIND_TIMEOUT:
                        begin
                            if (ready_reg)
                            begin
                                tmo_cnt_next = tmo_inc;
                                if (tmo_inc >= tmo_lim_reg)
                                    fault_next = 1'b1;
                            end
                        end
                        psc_pkg::KIND_INIT:
                        begin
                            raw_last_next     = in_sample;
                            filt_next         = {in_sample, 8'b0};
                            depth_now_next    = '0;
                            depth_before_next = '0;
                            zero_ref_next     = 16'(in_sample);
                            cal_next          = 1'b0;
                            ready_next        = 1'b1;
                        end
                        psc_pkg::KIND_ZERO_CAL, psc_pkg::KIND_ZERO_ONLY:
                        begin
                            zero_ref_next     = filt_counts;
                            depth_now_next    = '0;
                            depth_before_next = '0;
                            if (in_kind == psc_pkg::KIND_ZERO_CAL)
                                cal_next = 1'b1;
                        end
                        psc_pkg::KIND_LOAD_OFFSET:
                        begin
                            zero_ref_next = in_offset;
                            if (in_offset != '0)
                                cal_next = 1'b1;
                        end
                        psc_pkg::KIND_CLEAR_FAULT:
                        begin
                            fault_next     = 1'b0;
                            stuck_cnt_next = '0;
                            tmo_cnt_next   = '0;
                        end
                        default: ;  // unused kind: report only
                    endcase
                end
            end

            psc_pkg::ST_MUL_OLD:
            begin
                // alpha * old filter value
                mul_a      = filt_reg;
                mul_b      = {1'b0, alpha_reg};
                acc_next   = mul_p;
                state_next = psc_pkg::ST_MUL_NEW;
            end

            psc_pkg::ST_MUL_NEW:
            begin
                // (256 - alpha) * sample, scaled by 256, added to the old term
                mul_a             = FB'(samp_reg);
                mul_b             = psc_pkg::ALPHA_ONE - {1'b0, alpha_reg};
                filt_next         = filt_sum[FB+7:8];
                depth_before_next = depth_now_reg;
                state_next        = psc_pkg::ST_SCALE;
            end

            psc_pkg::ST_SCALE:
            begin
                // |filtered - zero| * num into the divider
                mul_a      = FB'(diff_mag);
                mul_b      = {1'b0, num_reg};
                neg_next   = diff[16];
                div_start  = 1'b1;
                state_next = psc_pkg::ST_DIV;
            end

            psc_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    depth_now_next = depth_sat;
                    state_next     = psc_pkg::ST_REPORT;
                end
            end

            psc_pkg::ST_REPORT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {6'b0, ready_reg, cal_reg, fault_reg, zero_ref_reg,
                                  raw_last_reg, dir, delta, depth_now_reg};
                state_next     = psc_pkg::ST_IDLE;
            end

            default:
                state_next = psc_pkg::ST_IDLE;
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= psc_pkg::ALPHA_RST;
            num_reg       <= psc_pkg::NUM_RST;
            den_reg       <= psc_pkg::DEN_RST;
            min_reg       <= psc_pkg::MIN_RST;
            max_reg       <= psc_pkg::MAX_RST;
            stuck_lim_reg <= psc_pkg::STUCK_LIM_RST;
            tmo_lim_reg   <= psc_pkg::TMO_LIM_RST;
            motion_reg    <= psc_pkg::MOTION_RST;
        end
        else if (cfg_we)
        begin
            case (psc_pkg::psc_cfg_t'(cfg_index))
                psc_pkg::CFG_ALPHA:     alpha_reg     <= cfg_data[7:0];
                psc_pkg::CFG_NUM:       num_reg       <= cfg_data[7:0];
                psc_pkg::CFG_DEN:       den_reg       <= cfg_data[7:0];
                psc_pkg::CFG_MIN:       min_reg       <= cfg_data;
                psc_pkg::CFG_MAX:       max_reg       <= cfg_data;
                psc_pkg::CFG_STUCK_LIM: stuck_lim_reg <= cfg_data[7:0];
                psc_pkg::CFG_TMO_LIM:   tmo_lim_reg   <= cfg_data[7:0];
                psc_pkg::CFG_MOTION:    motion_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= psc_pkg::ST_IDLE;
            filt_reg         <= '0;
            depth_now_reg    <= '0;
            depth_before_reg <= '0;
            zero_ref_reg     <= '0;
            raw_last_reg     <= '0;
            prev_raw_reg     <= '0;
            stuck_cnt_reg    <= '0;
            tmo_cnt_reg      <= '0;
            fault_reg        <= 1'b0;
            cal_reg          <= 1'b0;
            ready_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            filt_reg         <= filt_next;
            depth_now_reg    <= depth_now_next;
            depth_before_reg <= depth_before_next;
            zero_ref_reg     <= zero_ref_next;
            raw_last_reg     <= raw_last_next;
            prev_raw_reg     <= prev_raw_next;
            stuck_cnt_reg    <= stuck_cnt_next;
            tmo_cnt_reg      <= tmo_cnt_next;
            fault_reg        <= fault_next;
            cal_reg          <= cal_next;
            ready_reg        <= ready_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
